[sv/seg_pkg.sv]
// shared widths, side-band struct and a helper for the segment intersection pipeline
// no dependencies; imported by every module of the block
package seg_pkg;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;      // difference of two coordinates
    localparam int MAG_W   = COORD_W;          // magnitude of a difference
    localparam int PROD_W  = 2 * DIFF_W;       // one cross product term
    localparam int DET_W   = PROD_W + 1;       // determinant, signed
    localparam int SPLIT_W = 34;               // low slice of the multiplicand
    localparam int HI_W    = DET_W - 1 - SPLIT_W;
    localparam int Q_W     = COORD_W + 1;      // quotient bits
    localparam int DEN_W   = DET_W + 1;        // 2 * delta
    localparam int NUM_W   = DEN_W + Q_W;      // 2 * nl * |d| + delta
    localparam int SUM_W   = COORD_W + 3;      // a +/- step before clamping
    localparam logic [COORD_W-1:0] THR_RESET = '0;

    typedef struct packed {
        logic               hit;
        logic               neg_x;
        logic               neg_y;
        logic [COORD_W-1:0] a_x;
        logic [COORD_W-1:0] a_y;
    } seg_side_t;

    // magnitude of a nonzero-range difference, which never reaches 2^32
    function automatic logic [MAG_W-1:0] mag_of(input logic signed [DIFF_W-1:0] v);
        logic signed [DIFF_W-1:0] n;
        begin
            n = -v;
            mag_of = v[DIFF_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
        end
    endfunction

endpackage

[sv/seg_front.sv]
// front pipeline: differences, cross products, determinants, sign fix of delta, hit test,
// split products and rounding numerators of the crossing; six register stages
// depends on seg_pkg
module seg_front
    import seg_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [8*COORD_W-1:0]      in_data,
    input  logic [COORD_W-1:0]        thr,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [NUM_W-1:0]          num_x,
    output logic [NUM_W-1:0]          num_y,
    output logic [DEN_W-1:0]          den,
    output seg_side_t                 side
);

    localparam int NST = 6;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] v_in;
    logic [NST:0]   adv;

    always_comb begin
        adv[NST] = out_ready;
        for (int k = NST - 1; k >= 0; k--) begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    assign v_in      = {v_reg[NST-2:0], in_valid};
    assign in_ready  = adv[0];
    assign out_valid = v_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (adv[k]) begin
                    v_reg[k] <= v_in[k];
                end
            end
        end
    end

    // stage 1: coordinate differences
    logic signed [COORD_W-1:0] ax, ay, bx, by, cx, cy, dx, dy;
    assign ax = in_data[0*COORD_W +: COORD_W];
    assign ay = in_data[1*COORD_W +: COORD_W];
    assign bx = in_data[2*COORD_W +: COORD_W];
    assign by = in_data[3*COORD_W +: COORD_W];
    assign cx = in_data[4*COORD_W +: COORD_W];
    assign cy = in_data[5*COORD_W +: COORD_W];
    assign dx = in_data[6*COORD_W +: COORD_W];
    assign dy = in_data[7*COORD_W +: COORD_W];

    logic signed [DIFF_W-1:0] e1x_reg, e1y_reg, fx_reg, fy_reg, gx_reg, gy_reg;
    logic [COORD_W-1:0]       ax1_reg, ay1_reg;

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            e1x_reg <= DIFF_W'(bx) - DIFF_W'(ax);
            e1y_reg <= DIFF_W'(by) - DIFF_W'(ay);
            fx_reg  <= DIFF_W'(cx) - DIFF_W'(dx);
            fy_reg  <= DIFF_W'(cy) - DIFF_W'(dy);
            gx_reg  <= DIFF_W'(cx) - DIFF_W'(ax);
            gy_reg  <= DIFF_W'(cy) - DIFF_W'(ay);
            ax1_reg <= ax;
            ay1_reg <= ay;
        end
    end

    // stage 2: the six cross product terms
    logic signed [PROD_W-1:0] p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg;
    logic [MAG_W-1:0]         mx2_reg, my2_reg;
    seg_side_t                sd2_reg;

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            p1_reg <= e1x_reg * fy_reg;
            p2_reg <= fx_reg * e1y_reg;
            p3_reg <= gx_reg * fy_reg;
            p4_reg <= fx_reg * gy_reg;
            p5_reg <= e1x_reg * gy_reg;
            p6_reg <= gx_reg * e1y_reg;
            mx2_reg <= mag_of(e1x_reg);
            my2_reg <= mag_of(e1y_reg);
            sd2_reg <= '{hit: 1'b0, neg_x: e1x_reg[DIFF_W-1], neg_y: e1y_reg[DIFF_W-1],
                         a_x: ax1_reg, a_y: ay1_reg};
        end
    end

    // stage 3: determinants
    logic signed [DET_W-1:0] dl3_reg, nl3_reg, nm3_reg;
    logic [MAG_W-1:0]        mx3_reg, my3_reg;
    seg_side_t               sd3_reg;

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            dl3_reg <= DET_W'(p1_reg) - DET_W'(p2_reg);
            nl3_reg <= DET_W'(p3_reg) - DET_W'(p4_reg);
            nm3_reg <= DET_W'(p5_reg) - DET_W'(p6_reg);
            mx3_reg <= mx2_reg;
            my3_reg <= my2_reg;
            sd3_reg <= sd2_reg;
        end
    end

    // stage 4: make delta positive, flipping the numerators with it
    logic signed [DET_W-1:0] dl4_reg, nl4_reg, nm4_reg;
    logic [MAG_W-1:0]        mx4_reg, my4_reg;
    seg_side_t               sd4_reg;

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            if (dl3_reg[DET_W-1]) begin
                dl4_reg <= -dl3_reg;
                nl4_reg <= -nl3_reg;
                nm4_reg <= -nm3_reg;
            end else begin
                dl4_reg <= dl3_reg;
                nl4_reg <= nl3_reg;
                nm4_reg <= nm3_reg;
            end
            mx4_reg <= mx3_reg;
            my4_reg <= my3_reg;
            sd4_reg <= sd3_reg;
        end
    end

    // stage 5: hit test and split products nl * |d|
    logic hit5;
    assign hit5 = (dl4_reg > $signed({{(DET_W-COORD_W){1'b0}}, thr}))
                  && !nl4_reg[DET_W-1] && (nl4_reg <= dl4_reg)
                  && !nm4_reg[DET_W-1] && (nm4_reg <= dl4_reg);

    logic [SPLIT_W+MAG_W-1:0] lox_reg, loy_reg;
    logic [HI_W+MAG_W-1:0]    hix_reg, hiy_reg;
    logic [DET_W-2:0]         dl5_reg;
    seg_side_t                sd5_reg;

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            lox_reg <= nl4_reg[SPLIT_W-1:0] * mx4_reg;
            loy_reg <= nl4_reg[SPLIT_W-1:0] * my4_reg;
            hix_reg <= nl4_reg[DET_W-2:SPLIT_W] * mx4_reg;
            hiy_reg <= nl4_reg[DET_W-2:SPLIT_W] * my4_reg;
            dl5_reg <= dl4_reg[DET_W-2:0];
            sd5_reg <= '{hit: hit5, neg_x: sd4_reg.neg_x, neg_y: sd4_reg.neg_y,
                         a_x: sd4_reg.a_x, a_y: sd4_reg.a_y};
        end
    end

    // stage 6: rounding numerator 2*nl*|d| + delta and denominator 2*delta
    logic [NUM_W-1:0] nx6_reg, ny6_reg;
    logic [DEN_W-1:0] den6_reg;
    seg_side_t        sd6_reg;

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            nx6_reg  <= (NUM_W'(lox_reg) << 1) + (NUM_W'(hix_reg) << (SPLIT_W + 1))
                        + NUM_W'(dl5_reg);
            ny6_reg  <= (NUM_W'(loy_reg) << 1) + (NUM_W'(hiy_reg) << (SPLIT_W + 1))
                        + NUM_W'(dl5_reg);
            den6_reg <= {1'b0, dl5_reg, 1'b0};
            sd6_reg  <= sd5_reg;
        end
    end

    assign num_x = nx6_reg;
    assign num_y = ny6_reg;
    assign den   = den6_reg;
    assign side  = sd6_reg;

endmodule

[sv/seg_div.sv]
// pipelined restoring divider, one quotient bit per stage, two numerators
// over a shared denominator; depends on seg_pkg
module seg_div
    import seg_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [NUM_W-1:0] num_x,
    input  logic [NUM_W-1:0] num_y,
    input  logic [DEN_W-1:0] den,
    input  seg_side_t        in_side,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [Q_W-1:0]   quo_x,
    output logic [Q_W-1:0]   quo_y,
    output seg_side_t        out_side
);

    localparam int REM_W = NUM_W - Q_W;

    logic [Q_W-1:0]   v_reg;
    logic [Q_W-1:0]   v_in;
    logic [Q_W:0]     adv;
    logic [REM_W-1:0] rx_reg [Q_W];
    logic [REM_W-1:0] ry_reg [Q_W];
    logic [Q_W-1:0]   lx_reg [Q_W];
    logic [Q_W-1:0]   ly_reg [Q_W];
    logic [Q_W-1:0]   qx_reg [Q_W];
    logic [Q_W-1:0]   qy_reg [Q_W];
    logic [DEN_W-1:0] d_reg  [Q_W];
    seg_side_t        s_reg  [Q_W];

    // stage inputs: the pipeline entry for stage 0, the previous stage otherwise
    logic [REM_W-1:0] rx_in [Q_W];
    logic [REM_W-1:0] ry_in [Q_W];
    logic [Q_W-1:0]   lx_in [Q_W];
    logic [Q_W-1:0]   ly_in [Q_W];
    logic [Q_W-1:0]   qx_in [Q_W];
    logic [Q_W-1:0]   qy_in [Q_W];
    logic [DEN_W-1:0] d_in  [Q_W];
    seg_side_t        s_in  [Q_W];

    logic [REM_W-1:0] rx_next [Q_W];
    logic [REM_W-1:0] ry_next [Q_W];
    logic [Q_W-1:0]   lx_next [Q_W];
    logic [Q_W-1:0]   ly_next [Q_W];
    logic [Q_W-1:0]   qx_next [Q_W];
    logic [Q_W-1:0]   qy_next [Q_W];
    logic [DEN_W-1:0] d_next  [Q_W];
    seg_side_t        s_next  [Q_W];

    function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] r,
                                                input logic b,
                                                input logic [DEN_W-1:0] d);
        logic [REM_W:0] t;
        logic [REM_W:0] dd;
        logic [REM_W:0] df;
        begin
            t  = {r, b};
            dd = (REM_W + 1)'(d);
            df = t - dd;
            // lsb is the quotient bit, upper bits the new remainder
            if (t >= dd) div_step = {df[REM_W-1:0], 1'b1};
            else         div_step = {t[REM_W-1:0], 1'b0};
        end
    endfunction

    always_comb begin
        adv[Q_W] = out_ready;
        for (int k = Q_W - 1; k >= 0; k--) begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    always_comb begin
        rx_in[0] = num_x[NUM_W-1:Q_W];
        ry_in[0] = num_y[NUM_W-1:Q_W];
        lx_in[0] = num_x[Q_W-1:0];
        ly_in[0] = num_y[Q_W-1:0];
        qx_in[0] = '0;
        qy_in[0] = '0;
        d_in[0]  = den;
        s_in[0]  = in_side;
        for (int k = 1; k < Q_W; k++) begin
            rx_in[k] = rx_reg[k-1];
            ry_in[k] = ry_reg[k-1];
            lx_in[k] = lx_reg[k-1];
            ly_in[k] = ly_reg[k-1];
            qx_in[k] = qx_reg[k-1];
            qy_in[k] = qy_reg[k-1];
            d_in[k]  = d_reg[k-1];
            s_in[k]  = s_reg[k-1];
        end
    end

    always_comb begin
        logic [REM_W:0] sx, sy;
        for (int k = 0; k < Q_W; k++) begin
            sx = div_step(rx_in[k], lx_in[k][Q_W-1], d_in[k]);
            sy = div_step(ry_in[k], ly_in[k][Q_W-1], d_in[k]);
            rx_next[k] = sx[REM_W:1];
            ry_next[k] = sy[REM_W:1];
            lx_next[k] = lx_in[k] << 1;
            ly_next[k] = ly_in[k] << 1;
            qx_next[k] = {qx_in[k][Q_W-2:0], sx[0]};
            qy_next[k] = {qy_in[k][Q_W-2:0], sy[0]};
            d_next[k]  = d_in[k];
            s_next[k]  = s_in[k];
        end
    end

    assign v_in = {v_reg[Q_W-2:0], in_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int k = 0; k < Q_W; k++) begin
                if (adv[k]) begin
                    v_reg[k] <= v_in[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < Q_W; k++) begin
            if (adv[k]) begin
                rx_reg[k] <= rx_next[k];
                ry_reg[k] <= ry_next[k];
                lx_reg[k] <= lx_next[k];
                ly_reg[k] <= ly_next[k];
                qx_reg[k] <= qx_next[k];
                qy_reg[k] <= qy_next[k];
                d_reg[k]  <= d_next[k];
                s_reg[k]  <= s_next[k];
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[Q_W-1];
    assign quo_x     = qx_reg[Q_W-1];
    assign quo_y     = qy_reg[Q_W-1];
    assign out_side  = s_reg[Q_W-1];

endmodule

[sv/segment_intersection_unit.sv]
// segment intersection unit; input transaction to result passes 6 front stages,
// 33 divider stages and 1 output stage; throughput one pair per cycle while the
// output is not stalled by m_tready; every stage has its own valid bit, so
// bubbles close up and input is taken while a result waits
// synchronous active-low reset clears all valid bits and sets the threshold to THR_INIT (zero by default)
module segment_intersection_unit
    import seg_pkg::*;
#(
    parameter logic [COORD_W-1:0] THR_INIT = THR_RESET
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [8*COORD_W-1:0] s_tdata,   // a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [2*COORD_W-1:0] m_tdata,   // cross_x, cross_y
    output logic                 m_tuser,   // hit
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [COORD_W-1:0]   cfg_data   // parallel_threshold
);

    logic [COORD_W-1:0] thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_INIT;
        end else if (cfg_valid) begin
            thr_reg <= cfg_data;
        end
    end
    assign cfg_ready = 1'b1;

    logic             f_valid, f_ready;
    logic [NUM_W-1:0] f_num_x, f_num_y;
    logic [DEN_W-1:0] f_den;
    seg_side_t        f_side;

    seg_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .thr       (thr_reg),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .num_x     (f_num_x),
        .num_y     (f_num_y),
        .den       (f_den),
        .side      (f_side)
    );

    logic           d_valid, d_ready;
    logic [Q_W-1:0] d_qx, d_qy;
    seg_side_t      d_side;

    seg_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .num_x     (f_num_x),
        .num_y     (f_num_y),
        .den       (f_den),
        .in_side   (f_side),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .quo_x     (d_qx),
        .quo_y     (d_qy),
        .out_side  (d_side)
    );

    // apply sign of the direction, add the start point, clamp
    function automatic logic [COORD_W-1:0] place(input logic [COORD_W-1:0] a,
                                                 input logic neg,
                                                 input logic [Q_W-1:0] q);
        logic signed [SUM_W-1:0] st;
        logic signed [SUM_W-1:0] s;
        begin
            st = neg ? -$signed(SUM_W'(q)) : $signed(SUM_W'(q));
            s  = $signed({{(SUM_W-COORD_W){a[COORD_W-1]}}, a}) + st;
            if (s > $signed(SUM_W'({1'b0, {(COORD_W-1){1'b1}}})))
                place = {1'b0, {(COORD_W-1){1'b1}}};
            else if (s < -$signed(SUM_W'({1'b1, {(COORD_W-1){1'b0}}})))
                place = {1'b1, {(COORD_W-1){1'b0}}};
            else
                place = s[COORD_W-1:0];
        end
    endfunction

    logic                 out_v_reg;
    logic                 hit_reg;
    logic [2*COORD_W-1:0] pt_reg;

    assign d_ready = !out_v_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (d_ready) begin
            out_v_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (d_ready) begin
            hit_reg <= d_side.hit;
            pt_reg  <= d_side.hit ? {place(d_side.a_y, d_side.neg_y, d_qy),
                                     place(d_side.a_x, d_side.neg_x, d_qx)} : '0;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = pt_reg;
    assign m_tuser  = hit_reg;

    // a miss always carries a zero point
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("miss result with nonzero point");

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // a stalled result is not overwritten by the divider
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule
